FILE: sv/sorted_id_counter_table_assert.svh
// Assertion macros for the sorted id counter table.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef SORTED_ID_COUNTER_TABLE_ASSERT_SVH
`define SORTED_ID_COUNTER_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SICT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sict: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SICT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sict: next-cycle check failed");

`endif

FILE: sv/sict_pkg.sv
// Shared types and constants for the sorted id counter table.
// No dependencies; used by sict_ctrl, sict_dp and the top level.
package sict_pkg;

  localparam int unsigned MaxEntriesDef = 1024;
  localparam int unsigned UidW          = 31;
  localparam int unsigned AmountW       = 8;
  localparam int unsigned CountW        = 32;
  localparam int unsigned SlotW         = 10;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } sict_action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_ORDER     = 3'd3,
    STAT_SKIPPED   = 3'd4
  } sict_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_CMP,
    ST_COUNT,
    ST_FINISH
  } sict_state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,    // latch the input beat, open the search range
    CMD_APPEND,  // write new entry, result OK at the tail slot
    CMD_REJECT,  // result with the given status, count 0, slot 0
    CMD_PROBE,   // read key at the range midpoint
    CMD_STEP,    // narrow the range, or on a hit read the counter
    CMD_COUNT,   // finish the hit: saturating add or plain report
    CMD_PUSH     // move the result into the output register
  } sict_op_e;

  typedef struct packed {
    sict_op_e     op;
    sict_status_e res_status;
  } sict_cmd_t;

  typedef struct packed {
    sict_action_e action;
    logic         visible;
    logic         full;
    logic         order;
    logic         range_ok;
    logic         key_eq;
  } sict_sts_t;

endpackage

FILE: sv/sict_ctrl.sv
// Controller state machine for the sorted id counter table.
// Depends on sict_pkg; drives the datapath through sict_cmd_t.
module sict_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sict_pkg::sict_sts_t sts_i,
  output sict_pkg::sict_cmd_t cmd_o
);

  sict_pkg::sict_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  // A hit goes on to the counter, a miss probes the narrowed range.
  function automatic sict_pkg::sict_state_e sict_ctrl_next(input logic hit);
    return hit ? sict_pkg::ST_COUNT : sict_pkg::ST_SEARCH;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sict_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q & out_stall_i;
    cmd_o.op         = sict_pkg::CMD_NONE;
    cmd_o.res_status = sict_pkg::STAT_NOT_FOUND;
    unique case (state_q)
      sict_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = sict_pkg::CMD_LOAD;
          state_d  = sict_pkg::ST_DECODE;
        end
      end
      sict_pkg::ST_DECODE: begin
        state_d = sict_pkg::ST_FINISH;
        unique case (sts_i.action)
          sict_pkg::ACT_APPEND: begin
            if (sts_i.full) begin
              cmd_o.op         = sict_pkg::CMD_REJECT;
              cmd_o.res_status = sict_pkg::STAT_FULL;
            end else if (sts_i.order) begin
              cmd_o.op         = sict_pkg::CMD_REJECT;
              cmd_o.res_status = sict_pkg::STAT_ORDER;
            end else begin
              cmd_o.op = sict_pkg::CMD_APPEND;
            end
          end
          sict_pkg::ACT_ADD: begin
            if (!sts_i.visible) begin
              cmd_o.op         = sict_pkg::CMD_REJECT;
              cmd_o.res_status = sict_pkg::STAT_SKIPPED;
            end else begin
              state_d = sict_pkg::ST_SEARCH;
            end
          end
          sict_pkg::ACT_QUERY: state_d = sict_pkg::ST_SEARCH;
          sict_pkg::ACT_NOP: begin
            cmd_o.op         = sict_pkg::CMD_REJECT;
            cmd_o.res_status = sict_pkg::STAT_NOT_FOUND;
          end
          default: state_d = sict_pkg::ST_IDLE;
        endcase
      end
      sict_pkg::ST_SEARCH: begin
        if (sts_i.range_ok) begin
          cmd_o.op = sict_pkg::CMD_PROBE;
          state_d  = sict_pkg::ST_CMP;
        end else begin
          cmd_o.op         = sict_pkg::CMD_REJECT;
          cmd_o.res_status = sict_pkg::STAT_NOT_FOUND;
          state_d          = sict_pkg::ST_FINISH;
        end
      end
      sict_pkg::ST_CMP: begin
        cmd_o.op = sict_pkg::CMD_STEP;
        state_d  = sict_ctrl_next(sts_i.key_eq);
      end
      sict_pkg::ST_COUNT: begin
        cmd_o.op = sict_pkg::CMD_COUNT;
        state_d  = sict_pkg::ST_FINISH;
      end
      sict_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = sict_pkg::CMD_PUSH;
          out_valid_d = 1'b1;
          state_d     = sict_pkg::ST_IDLE;
        end
      end
      default: state_d = sict_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != sict_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/sict_dp.sv
// Datapath for the sorted id counter table: key and counter memories,
// search range, result and output registers. Depends on sict_pkg.
module sict_dp #(
  parameter int unsigned MaxEntries = sict_pkg::MaxEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sict_pkg::sict_cmd_t             cmd_i,
  output sict_pkg::sict_sts_t             sts_o,
  input  logic [1:0]                      action_i,
  input  logic [sict_pkg::UidW-1:0]       uid_i,
  input  logic [sict_pkg::AmountW-1:0]    amount_i,
  input  logic                            visible_i,
  output logic [2:0]                      status_o,
  output logic [sict_pkg::CountW-1:0]     count_o,
  output logic [sict_pkg::SlotW-1:0]      slot_o
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned TotW = $clog2(MaxEntries + 1);
  localparam logic [TotW-1:0] FullTotal = TotW'(MaxEntries);

  logic [sict_pkg::UidW-1:0]   key_mem [MaxEntries];
  logic [sict_pkg::CountW-1:0] cnt_mem [MaxEntries];

  sict_pkg::sict_action_e        action_q;
  logic [sict_pkg::UidW-1:0]     uid_q;
  logic [sict_pkg::AmountW-1:0]  amount_q;
  logic                          visible_q;
  logic [TotW-1:0]               total_q;
  logic [sict_pkg::UidW-1:0]     last_key_q;
  logic [TotW-1:0]               lo_q, hi_q;
  logic [IdxW-1:0]               pos_q;
  logic [sict_pkg::UidW-1:0]     key_rd_q;
  logic [sict_pkg::CountW-1:0]   cnt_rd_q;
  sict_pkg::sict_status_e        res_status_q;
  logic [sict_pkg::CountW-1:0]   res_count_q;
  logic [sict_pkg::SlotW-1:0]    res_slot_q;
  logic [2:0]                    out_status_q;
  logic [sict_pkg::CountW-1:0]   out_count_q;
  logic [sict_pkg::SlotW-1:0]    out_slot_q;

  logic [TotW-1:0]             mid_w;
  logic [IdxW-1:0]             mid;
  logic                        key_eq, key_lt;
  logic [sict_pkg::CountW:0]   sum;
  logic [sict_pkg::CountW-1:0] sat_sum, hit_count;
  logic                        cnt_we;
  logic [IdxW-1:0]             cnt_wa;
  logic [sict_pkg::CountW-1:0] cnt_wd;

  assign mid_w  = lo_q + ((hi_q - lo_q) >> 1);
  assign mid    = mid_w[IdxW-1:0];
  assign key_eq = (uid_q == key_rd_q);
  assign key_lt = (uid_q < key_rd_q);

  assign sum       = (sict_pkg::CountW+1)'(cnt_rd_q) + (sict_pkg::CountW+1)'(amount_q);
  assign sat_sum   = sum[sict_pkg::CountW] ? '1 : sum[sict_pkg::CountW-1:0];
  assign hit_count = (action_q == sict_pkg::ACT_ADD) ? sat_sum : cnt_rd_q;

  assign cnt_we = (cmd_i.op == sict_pkg::CMD_APPEND) ||
                  ((cmd_i.op == sict_pkg::CMD_COUNT) && (action_q == sict_pkg::ACT_ADD));
  assign cnt_wa = (cmd_i.op == sict_pkg::CMD_APPEND) ? total_q[IdxW-1:0] : pos_q;
  assign cnt_wd = (cmd_i.op == sict_pkg::CMD_APPEND) ? '0 : sat_sum;

  // Key memory: one write port (append), one registered read (probe).
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sict_pkg::CMD_APPEND) begin
      key_mem[total_q[IdxW-1:0]] <= uid_q;
    end
    if (cmd_i.op == sict_pkg::CMD_PROBE) begin
      key_rd_q <= key_mem[mid];
    end
  end

  // Counter memory: written on append or add, read on a search hit.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if ((cmd_i.op == sict_pkg::CMD_STEP) && key_eq) begin
      cnt_rd_q <= cnt_mem[mid];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.op == sict_pkg::CMD_APPEND) begin
      total_q <= total_q + TotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      sict_pkg::CMD_LOAD: begin
        action_q  <= sict_pkg::sict_action_e'(action_i);
        uid_q     <= uid_i;
        amount_q  <= amount_i;
        visible_q <= visible_i;
        lo_q      <= '0;
        hi_q      <= total_q;
      end
      sict_pkg::CMD_APPEND: begin
        last_key_q   <= uid_q;
        res_status_q <= sict_pkg::STAT_OK;
        res_count_q  <= '0;
        res_slot_q   <= sict_pkg::SlotW'(total_q);
      end
      sict_pkg::CMD_REJECT: begin
        res_status_q <= cmd_i.res_status;
        res_count_q  <= '0;
        res_slot_q   <= '0;
      end
      sict_pkg::CMD_STEP: begin
        if (key_lt) begin
          hi_q <= mid_w;
        end else if (!key_eq) begin
          lo_q <= mid_w + TotW'(1);
        end else begin
          pos_q <= mid;
        end
      end
      sict_pkg::CMD_COUNT: begin
        res_status_q <= sict_pkg::STAT_OK;
        res_count_q  <= hit_count;
        res_slot_q   <= sict_pkg::SlotW'(pos_q);
      end
      sict_pkg::CMD_PUSH: begin
        out_status_q <= res_status_q;
        out_count_q  <= res_count_q;
        out_slot_q   <= res_slot_q;
      end
      default: ;
    endcase
  end

  assign sts_o.action   = action_q;
  assign sts_o.visible  = visible_q;
  assign sts_o.full     = (total_q >= FullTotal);
  assign sts_o.order    = (total_q != '0) && (uid_q <= last_key_q);
  assign sts_o.range_ok = (lo_q < hi_q);
  assign sts_o.key_eq   = key_eq;

  assign status_o = out_status_q;
  assign count_o  = out_count_q;
  assign slot_o   = out_slot_q;

endmodule

FILE: sv/sorted_id_counter_table.sv
// Top level of the sorted id counter table: controller plus datapath.
// Depends on sict_pkg, sict_ctrl, sict_dp and sorted_id_counter_table_assert.svh.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+----------------------------------
//   in      | in_valid_i  | in_stall_o   | action_i uid_i amount_i visible_i
//   out     | out_valid_o | out_stall_i  | status_o count_o slot_o
//
// One beat in, one beat out. A search makes k <= clog2(entries + 1) probes,
// paced by the key memory's single registered read port.
// Reset clears the entry count and handshake state, not the memories; only
// entries below the count are ever read. A finished result waits in the
// output register; the next input beat is accepted while it is stalled.
module sorted_id_counter_table #(
  parameter int unsigned MAX_ENTRIES = sict_pkg::MaxEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [sict_pkg::UidW-1:0]    uid_i,
  input  logic [sict_pkg::AmountW-1:0] amount_i,
  input  logic                         visible_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [sict_pkg::CountW-1:0]  count_o,
  output logic [sict_pkg::SlotW-1:0]   slot_o
);

  // Controller and datapath talk only through these two structs.
  sict_pkg::sict_cmd_t cmd;
  sict_pkg::sict_sts_t sts;

  // Sequencer: accept, decode, probe/compare loop, counter update, push.
  sict_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Memories, search range registers, saturating adder, output register.
  sict_dp #(
    .MaxEntries (MAX_ENTRIES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .action_i  (action_i),
    .uid_i     (uid_i),
    .amount_i  (amount_i),
    .visible_i (visible_i),
    .status_o  (status_o),
    .count_o   (count_o),
    .slot_o    (slot_o)
  );

`include "sorted_id_counter_table_assert.svh"

  // An accepted beat keeps the block busy for at least the next cycle.
  `SICT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // A result only moves out when the output register is free or being taken.
  `SICT_ASSERT_NOW(a_push_when_free, cmd.op == sict_pkg::CMD_PUSH, !out_valid_o || !out_stall_i)
  // The key memory is only probed inside a non-empty search range.
  `SICT_ASSERT_NOW(a_probe_in_range, cmd.op == sict_pkg::CMD_PROBE, sts.range_ok)
  // An append never lands in a full table.
  `SICT_ASSERT_NOW(a_append_not_full, cmd.op == sict_pkg::CMD_APPEND, !sts.full)

endmodule
